FILE: rtl/stq_pkg.sv
// Shared types, codes and helpers for the sorted timer queue.
// Used by stq_ram, stq_ctrl, stq_out_reg and sorted_timer_queue_unit.
package stq_pkg;

  localparam int ID_W     = 4;
  localparam int ID_COUNT = 16;
  localparam int TIME_W   = 32;
  localparam int OP_W     = 2;
  localparam int ST_W     = 3;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL = 2'd2;
  localparam logic [OP_W-1:0] OP_SHUT = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_DUE       = 3'd1;
  localparam logic [ST_W-1:0] ST_NONE      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
  localparam logic [ST_W-1:0] ST_DUP       = 3'd5;
  localparam logic [ST_W-1:0] ST_SHUT      = 3'd6;

  // One result item.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wake;
    logic              shut;
    logic              last;
  } res_t;

  // Access request to the node memories (wake time and next link per handle).
  typedef struct packed {
    logic              rd_en;
    logic [ID_W-1:0]   rd_addr;
    logic              time_we;
    logic              next_we;
    logic [ID_W-1:0]   wr_addr;
    logic [TIME_W-1:0] wr_time;
    logic [ID_W-1:0]   wr_next;
  } mem_req_t;

  // True when a - b, read as a signed value, is positive.
  function automatic logic later_than(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

FILE: rtl/stq_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// One entry per timer handle; depth from stq_pkg.
module stq_ram #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [stq_pkg::ID_W-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data,
  input  logic                    wr_en,
  input  logic [stq_pkg::ID_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]        wr_data
);

  logic [WIDTH-1:0] mem [stq_pkg::ID_COUNT];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds while no read is issued.
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/stq_out_reg.sv
// Output register for result items; decouples the controller from out_stall.
// Depends on stq_pkg for the result type.
module stq_out_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  stq_pkg::res_t             res,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [stq_pkg::ST_W-1:0]  out_status,
  output logic [stq_pkg::ID_W-1:0]  out_due_id,
  output logic [stq_pkg::TIME_W-1:0] out_due_time,
  output logic                      out_is_shut_down,
  output logic                      out_last
);

  logic          valid_r;
  stq_pkg::res_t data_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = data_r.status;
  assign out_due_id       = data_r.id;
  assign out_due_time     = data_r.wake;
  assign out_is_shut_down = data_r.shut;
  assign out_last         = data_r.last;

endmodule

FILE: rtl/stq_ctrl.sv
// Sequencer of the timer queue: walks the linked list held in the node memories.
// Depends on stq_pkg; drives the stq_ram pair and stq_out_reg.
module stq_ctrl #(
  parameter int TIMER_COUNT = 16,
  parameter int CNT_W       = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       busy,
  input  logic [stq_pkg::OP_W-1:0]   in_op,
  input  logic [stq_pkg::ID_W-1:0]   in_timer_id,
  input  logic [stq_pkg::TIME_W-1:0] in_wake_time,
  input  logic [stq_pkg::TIME_W-1:0] in_current_time,
  output stq_pkg::mem_req_t          mem_req,
  input  logic [stq_pkg::TIME_W-1:0] rd_time,
  input  logic [stq_pkg::ID_W-1:0]   rd_next,
  output logic                       res_push,
  output stq_pkg::res_t              res,
  input  logic                       res_free
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_ADD_WALK = 4'd2;
  localparam logic [3:0] S_ADD_LINK = 4'd3;
  localparam logic [3:0] S_DEL_HEAD = 4'd4;
  localparam logic [3:0] S_DEL_WALK = 4'd5;
  localparam logic [3:0] S_DEL_SKIP = 4'd6;
  localparam logic [3:0] S_POLL_CHK = 4'd7;
  localparam logic [3:0] S_POLL_END = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TIMER_COUNT);

  logic [3:0]                   state_r, state_nxt;
  logic [stq_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [stq_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [stq_pkg::TIME_W-1:0]   wake_r, wake_nxt;
  logic [stq_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [stq_pkg::ID_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             pos_r, pos_nxt;
  logic [stq_pkg::ID_W-1:0]     cur_r, cur_nxt;
  logic [stq_pkg::ID_W-1:0]     prev_r, prev_nxt;
  logic [stq_pkg::ID_COUNT-1:0] mark_r, mark_nxt;
  logic                         shut_r, shut_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [stq_pkg::ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [stq_pkg::TIME_W-1:0]   pend_time_r, pend_time_nxt;
  logic [stq_pkg::ST_W-1:0]     st_r, st_nxt;
  logic                         due;

  assign busy = (state_r != S_IDLE);
  assign due  = !stq_pkg::later_than(rd_time, now_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    wake_nxt      = wake_r;
    now_nxt       = now_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    mark_nxt      = mark_r;
    shut_nxt      = shut_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    pend_time_nxt = pend_time_r;
    st_nxt        = st_r;
    mem_req       = '0;
    res_push      = 1'b0;
    res           = '{status: stq_pkg::ST_OK, id: '0, wake: '0, shut: shut_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          id_nxt    = in_timer_id;
          wake_nxt  = in_wake_time;
          now_nxt   = in_current_time;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (op_r)
          stq_pkg::OP_ADD: begin
            if (mark_r[id_r]) begin
              st_nxt    = stq_pkg::ST_DUP;
              state_nxt = S_RESP;
            end else if (count_r >= CNT_FULL) begin
              st_nxt    = stq_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else if (count_r == '0) begin
              mem_req.time_we = 1'b1;
              mem_req.next_we = 1'b1;
              mem_req.wr_addr = id_r;
              mem_req.wr_time = wake_r;
              head_nxt        = id_r;
              count_nxt       = count_r + CNT_ONE;
              mark_nxt[id_r]  = 1'b1;
              st_nxt          = stq_pkg::ST_OK;
              state_nxt       = S_RESP;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r;
              cur_nxt         = head_r;
              pos_nxt         = '0;
              state_nxt       = S_ADD_WALK;
            end
          end
          stq_pkg::OP_DEL: begin
            if (!mark_r[id_r]) begin
              st_nxt    = stq_pkg::ST_NOT_FOUND;
              state_nxt = S_RESP;
            end else if (head_r == id_r) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = id_r;
              state_nxt       = S_DEL_HEAD;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r;
              cur_nxt         = head_r;
              state_nxt       = S_DEL_WALK;
            end
          end
          stq_pkg::OP_POLL: begin
            if (shut_r) begin
              st_nxt    = stq_pkg::ST_SHUT;
              state_nxt = S_RESP;
            end else if (count_r == '0) begin
              st_nxt    = stq_pkg::ST_NONE;
              state_nxt = S_RESP;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r;
              state_nxt       = S_POLL_CHK;
            end
          end
          stq_pkg::OP_SHUT: begin
            shut_nxt  = 1'b1;
            st_nxt    = stq_pkg::ST_OK;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // Read data holds the entry at cur_r. The new timer goes before the
      // first entry that is strictly later, so equal times keep their order.
      S_ADD_WALK: begin
        if (stq_pkg::later_than(rd_time, wake_r)) begin
          mem_req.time_we = 1'b1;
          mem_req.next_we = 1'b1;
          mem_req.wr_addr = id_r;
          mem_req.wr_time = wake_r;
          mem_req.wr_next = cur_r;
          if (pos_r == '0) begin
            head_nxt       = id_r;
            count_nxt      = count_r + CNT_ONE;
            mark_nxt[id_r] = 1'b1;
            st_nxt         = stq_pkg::ST_OK;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_ADD_LINK;
          end
        end else if (pos_r + CNT_ONE == count_r) begin
          mem_req.time_we = 1'b1;
          mem_req.next_we = 1'b1;
          mem_req.wr_addr = id_r;
          mem_req.wr_time = wake_r;
          mem_req.wr_next = rd_next;
          prev_nxt        = cur_r;
          state_nxt       = S_ADD_LINK;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_next;
          prev_nxt        = cur_r;
          cur_nxt         = rd_next;
          pos_nxt         = pos_r + CNT_ONE;
        end
      end

      S_ADD_LINK: begin
        mem_req.next_we = 1'b1;
        mem_req.wr_addr = prev_r;
        mem_req.wr_next = id_r;
        count_nxt       = count_r + CNT_ONE;
        mark_nxt[id_r]  = 1'b1;
        st_nxt          = stq_pkg::ST_OK;
        state_nxt       = S_RESP;
      end

      S_DEL_HEAD: begin
        head_nxt       = rd_next;
        count_nxt      = count_r - CNT_ONE;
        mark_nxt[id_r] = 1'b0;
        st_nxt         = stq_pkg::ST_OK;
        state_nxt      = S_RESP;
      end

      // The handle is known to be queued, so the walk always finds its predecessor.
      S_DEL_WALK: begin
        mem_req.rd_en = 1'b1;
        if (rd_next == id_r) begin
          mem_req.rd_addr = id_r;
          state_nxt       = S_DEL_SKIP;
        end else begin
          mem_req.rd_addr = rd_next;
          cur_nxt         = rd_next;
        end
      end

      S_DEL_SKIP: begin
        mem_req.next_we = 1'b1;
        mem_req.wr_addr = cur_r;
        mem_req.wr_next = rd_next;
        count_nxt       = count_r - CNT_ONE;
        mark_nxt[id_r]  = 1'b0;
        st_nxt          = stq_pkg::ST_OK;
        state_nxt       = S_RESP;
      end

      // A due entry is held back one step, so that the last flag is known
      // when it is sent.
      S_POLL_CHK: begin
        if (due) begin
          if (!pend_v_r || res_free) begin
            if (pend_v_r) begin
              res_push = 1'b1;
              res      = '{status: stq_pkg::ST_DUE, id: pend_id_r, wake: pend_time_r,
                           shut: shut_r, last: 1'b0};
            end
            pend_v_nxt       = 1'b1;
            pend_id_nxt      = head_r;
            pend_time_nxt    = rd_time;
            head_nxt         = rd_next;
            count_nxt        = count_r - CNT_ONE;
            mark_nxt[head_r] = 1'b0;
            if (count_r == CNT_ONE) begin
              state_nxt = S_POLL_END;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = rd_next;
            end
          end
        end else begin
          state_nxt = S_POLL_END;
        end
      end

      S_POLL_END: begin
        if (res_free) begin
          res_push = 1'b1;
          if (pend_v_r) begin
            res = '{status: stq_pkg::ST_DUE, id: pend_id_r, wake: pend_time_r,
                    shut: shut_r, last: 1'b1};
          end else begin
            res.status = stq_pkg::ST_NONE;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      S_RESP: begin
        if (res_free) begin
          res_push   = 1'b1;
          res.status = st_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      mark_r   <= '0;
      shut_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      mark_r   <= mark_nxt;
      shut_r   <= shut_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    wake_r      <= wake_nxt;
    now_r       <= now_nxt;
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_time_r <= pend_time_nxt;
    st_r        <= st_nxt;
  end

endmodule

FILE: rtl/sorted_timer_queue_unit.sv
// Top level of the sorted timer queue: controller, node memories, output register.
// Depends on stq_pkg, stq_ram, stq_ctrl and stq_out_reg.
//
//   Channel   Handshake                 Payload
//   in        in_valid / in_stall       in_op, in_timer_id, in_wake_time, in_current_time
//   out       out_valid / out_stall     out_status, out_due_id, out_due_time,
//                                       out_is_shut_down, out_last
//
// Timers form a linked list in wake-time order, one memory entry per handle.
// A rejected item, a shut down, an add to an empty queue and a poll of an empty or shut
// down queue need no memory read. An add walks the list from the head to the first entry
// that is strictly later, or to the tail; a delete of a non-head entry walks to its predecessor.
// A poll reads from the head and removes each due timer in turn. One item is in work at a
// time; in_stall is high from acceptance until its last result is in the output register,
// so out_stall can hold it longer.
// Reset is synchronous and empties the queue.
module sorted_timer_queue_unit #(
  parameter int TIMER_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [stq_pkg::OP_W-1:0]   in_op,
  input  logic [stq_pkg::ID_W-1:0]   in_timer_id,
  input  logic [stq_pkg::TIME_W-1:0] in_wake_time,
  input  logic [stq_pkg::TIME_W-1:0] in_current_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [stq_pkg::ST_W-1:0]   out_status,
  output logic [stq_pkg::ID_W-1:0]   out_due_id,
  output logic [stq_pkg::TIME_W-1:0] out_due_time,
  output logic                       out_is_shut_down,
  output logic                       out_last
);

  localparam int CNT_W = $clog2(TIMER_COUNT + 1);

  stq_pkg::mem_req_t          mem_req;
  stq_pkg::res_t              res;
  logic [stq_pkg::TIME_W-1:0] rd_time;
  logic [stq_pkg::ID_W-1:0]   rd_next;
  logic                       res_push;
  logic                       res_free;
  logic                       busy;

  assign in_stall = busy;

  stq_ctrl #(
    .TIMER_COUNT(TIMER_COUNT),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .busy           (busy),
    .in_op          (in_op),
    .in_timer_id    (in_timer_id),
    .in_wake_time   (in_wake_time),
    .in_current_time(in_current_time),
    .mem_req        (mem_req),
    .rd_time        (rd_time),
    .rd_next        (rd_next),
    .res_push       (res_push),
    .res            (res),
    .res_free       (res_free)
  );

  stq_ram #(.WIDTH(stq_pkg::TIME_W)) u_time_ram (
    .clk    (clk),
    .rd_en  (mem_req.rd_en),
    .rd_addr(mem_req.rd_addr),
    .rd_data(rd_time),
    .wr_en  (mem_req.time_we),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_time)
  );

  stq_ram #(.WIDTH(stq_pkg::ID_W)) u_next_ram (
    .clk    (clk),
    .rd_en  (mem_req.rd_en),
    .rd_addr(mem_req.rd_addr),
    .rd_data(rd_next),
    .wr_en  (mem_req.next_we),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_next)
  );

  stq_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (res_push),
    .res             (res),
    .free            (res_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_due_id      (out_due_id),
    .out_due_time    (out_due_time),
    .out_is_shut_down(out_is_shut_down),
    .out_last        (out_last)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_free)
    else $error("result pushed while the output register is full");

  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !res_push)
    else $error("result pushed while no item is in work");

  a_time_with_link: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.time_we |-> mem_req.next_we)
    else $error("wake time written without its link");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not stall the input");

endmodule
